// ===== hdl/tlpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpc_pkg: shared definitions for the pedestrian traffic light controller
// Widths, register indexes, reset durations, lamp words and the phase type.
// ----------------------------------------------------------------------------
package tlpc_pkg;

    localparam int DUR_W       = 14;
    localparam int LAMP_W      = 8;
    localparam int KEY_W       = 2;
    localparam int CFG_INDEX_W = 3;

    localparam int TICK_MS_DEFAULT = 500;

    localparam logic [DUR_W-1:0] ELAPSED_MAX = {DUR_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_RED_BEFORE_NS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NS_GREEN      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NS_YELLOW     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_BEFORE_EW = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EW_GREEN      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EW_YELLOW     = 3'd5;

    // Reset durations in milliseconds.
    localparam logic [DUR_W-1:0] RST_RED_BEFORE_NS = 14'd500;
    localparam logic [DUR_W-1:0] RST_NS_GREEN      = 14'd6000;
    localparam logic [DUR_W-1:0] RST_NS_YELLOW     = 14'd2000;
    localparam logic [DUR_W-1:0] RST_RED_BEFORE_EW = 14'd500;
    localparam logic [DUR_W-1:0] RST_EW_GREEN      = 14'd6000;
    localparam logic [DUR_W-1:0] RST_EW_YELLOW     = 14'd2000;

    // Lamp words.
    localparam logic [LAMP_W-1:0] LAMP_RR     = 8'h24;
    localparam logic [LAMP_W-1:0] LAMP_GR     = 8'h21;
    localparam logic [LAMP_W-1:0] LAMP_YR     = 8'h22;
    localparam logic [LAMP_W-1:0] LAMP_RG     = 8'h0C;
    localparam logic [LAMP_W-1:0] LAMP_RY     = 8'h14;
    localparam logic [LAMP_W-1:0] LAMP_GR_PED = 8'h61;
    localparam logic [LAMP_W-1:0] LAMP_RG_PED = 8'h8C;

    typedef enum logic [5:0] {
        PH_RED_NS    = 6'b000001,
        PH_NS_GREEN  = 6'b000010,
        PH_NS_YELLOW = 6'b000100,
        PH_RED_EW    = 6'b001000,
        PH_EW_GREEN  = 6'b010000,
        PH_EW_YELLOW = 6'b100000
    } phase_t;

    // One accepted input beat as seen by the controller core.
    typedef struct packed {
        logic             valid;
        logic             tick;
        logic [KEY_W-1:0] key_edges;
    } item_t;

    // Configuration write as seen by the controller core.
    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [DUR_W-1:0]       data;
    } cfg_wr_t;

endpackage

// ===== hdl/tlpc_core.sv =====
// ----------------------------------------------------------------------------
// tlpc_core: phase sequencer of the pedestrian traffic light controller
// Holds the durations, phase, elapsed counter and requests; updates all but
// the durations on each accepted beat and presents the updated lamp word.
// ----------------------------------------------------------------------------
module tlpc_core
    import tlpc_pkg::*;
#(
    parameter int TICK_MS = TICK_MS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_wr_t           cfg,
    input  item_t             item,
    output logic [LAMP_W-1:0] lamps_next
);

    localparam logic [DUR_W:0] TICK_INC = (DUR_W+1)'(TICK_MS);

    logic [DUR_W-1:0] dur_reg [6];
    phase_t           phase_reg,   phase_next;
    logic             ped_reg,     ped_next;
    logic [DUR_W-1:0] elapsed_reg, elapsed_next;
    logic             ns_req_reg,  ns_req_next;
    logic             ew_req_reg,  ew_req_next;

    logic [DUR_W:0]   sum;
    logic [DUR_W-1:0] dur_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg[0] <= RST_RED_BEFORE_NS;
            dur_reg[1] <= RST_NS_GREEN;
            dur_reg[2] <= RST_NS_YELLOW;
            dur_reg[3] <= RST_RED_BEFORE_EW;
            dur_reg[4] <= RST_EW_GREEN;
            dur_reg[5] <= RST_EW_YELLOW;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                REG_RED_BEFORE_NS: dur_reg[0] <= cfg.data;
                REG_NS_GREEN:      dur_reg[1] <= cfg.data;
                REG_NS_YELLOW:     dur_reg[2] <= cfg.data;
                REG_RED_BEFORE_EW: dur_reg[3] <= cfg.data;
                REG_EW_GREEN:      dur_reg[4] <= cfg.data;
                REG_EW_YELLOW:     dur_reg[5] <= cfg.data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        ns_req_next  = ns_req_reg;
        ew_req_next  = ew_req_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        ped_next     = ped_reg;
        sum          = {1'b0, elapsed_reg} + TICK_INC;

        // A north-south edge wins when both keys arrive in the same beat.
        if (item.key_edges[0])
        begin
            ns_req_next = 1'b1;
        end
        else if (item.key_edges[1])
        begin
            ew_req_next = 1'b1;
        end

        if (item.tick)
        begin
            elapsed_next = sum[DUR_W] ? ELAPSED_MAX : sum[DUR_W-1:0];
        end

        case (phase_reg)
            PH_RED_NS:    dur_sel = dur_reg[0];
            PH_NS_GREEN:  dur_sel = dur_reg[1];
            PH_NS_YELLOW: dur_sel = dur_reg[2];
            PH_RED_EW:    dur_sel = dur_reg[3];
            PH_EW_GREEN:  dur_sel = dur_reg[4];
            PH_EW_YELLOW: dur_sel = dur_reg[5];
            default:      dur_sel = '0;
        endcase

        if (elapsed_next >= dur_sel)
        begin
            elapsed_next = '0;
            ped_next     = 1'b0;
            case (phase_reg)
                PH_RED_NS:
                begin
                    phase_next = PH_NS_GREEN;
                    if (ns_req_next)
                    begin
                        ped_next    = 1'b1;
                        ns_req_next = 1'b0;
                    end
                end
                PH_NS_GREEN:  phase_next = PH_NS_YELLOW;
                PH_NS_YELLOW: phase_next = PH_RED_EW;
                PH_RED_EW:
                begin
                    phase_next = PH_EW_GREEN;
                    if (ew_req_next)
                    begin
                        ped_next    = 1'b1;
                        ew_req_next = 1'b0;
                    end
                end
                PH_EW_GREEN:  phase_next = PH_EW_YELLOW;
                default:      phase_next = PH_RED_NS;
            endcase
        end

        case (phase_next)
            PH_NS_GREEN:  lamps_next = ped_next ? LAMP_GR_PED : LAMP_GR;
            PH_NS_YELLOW: lamps_next = LAMP_YR;
            PH_EW_GREEN:  lamps_next = ped_next ? LAMP_RG_PED : LAMP_RG;
            PH_EW_YELLOW: lamps_next = LAMP_RY;
            default:      lamps_next = LAMP_RR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RED_NS;
            ped_reg     <= 1'b0;
            elapsed_reg <= '0;
            ns_req_reg  <= 1'b0;
            ew_req_reg  <= 1'b0;
        end
        else if (item.valid)
        begin
            phase_reg   <= phase_next;
            ped_reg     <= ped_next;
            elapsed_reg <= elapsed_next;
            ns_req_reg  <= ns_req_next;
            ew_req_reg  <= ew_req_next;
        end
    end

endmodule

// ===== hdl/traffic_light_ped_controller.sv =====
// ----------------------------------------------------------------------------
// traffic_light_ped_controller: two-road traffic light with pedestrian keys
// Six-phase light sequencer driven by timer ticks, with latched pedestrian
// requests and configurable phase durations.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel carries one beat per event: a tick bit and two key edge
// bits. Each accepted beat produces exactly one output beat carrying the
// eight-bit lamp word of the phase that holds after that beat is applied.
// The controller state is updated in the cycle the input beat is accepted,
// and its lamp word is registered into the main output register, or into
// the skid register if that is stalled. A new beat can be accepted every
// cycle while in_stall is low, sustaining one beat per cycle.
// The output side has a main register and a skid register. If the receiver
// asserts out_stall, the next result drops into the skid register, and
// in_stall rises only once both hold a result. Results are never dropped.
// Reset (rst_n low, asynchronous) loads the default durations, puts the
// light in the all-red phase before north-south green, clears the elapsed
// counter and both requests, and empties the output registers.
// Durations are written through cfg_we, cfg_index and cfg_data while the
// block is idle, a rule on the user that the block does not enforce;
// indexes six and seven are ignored.
// ----------------------------------------------------------------------------
module traffic_light_ped_controller
    import tlpc_pkg::*;
#(
    parameter int TICK_MS = TICK_MS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   tick,
    input  logic [KEY_W-1:0]       key_edges,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LAMP_W-1:0]      lamps
);

    item_t             item;
    cfg_wr_t           cfg;
    logic [LAMP_W-1:0] lamps_next;

    logic              out_valid_reg;
    logic [LAMP_W-1:0] out_lamps_reg;
    logic              skid_valid_reg;
    logic [LAMP_W-1:0] skid_lamps_reg;
    logic              out_free;

    // The skid register being full is the only reason to hold off the sender.
    assign in_stall = skid_valid_reg;

    assign item.valid     = in_valid && !in_stall;
    assign item.tick      = tick;
    assign item.key_edges = key_edges;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    tlpc_core #(
        .TICK_MS (TICK_MS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .lamps_next (lamps_next)
    );

    // The main output register can take a new beat when it is empty or its
    // beat is being taken in this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                // No input is accepted while the skid register is full.
                if (out_free)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (out_free)
            begin
                out_valid_reg <= item.valid;
            end
            else if (item.valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_lamps_reg <= skid_lamps_reg;
            end
        end
        else if (out_free)
        begin
            if (item.valid)
            begin
                out_lamps_reg <= lamps_next;
            end
        end
        else if (item.valid)
        begin
            skid_lamps_reg <= lamps_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign lamps     = out_lamps_reg;

endmodule

// ===== hdl/tlpc_checker.sv =====
// ----------------------------------------------------------------------------
// tlpc_port_props: port-level checks for the pedestrian traffic light controller
// Watches the handshakes and lamp word at the top-level ports.
// ----------------------------------------------------------------------------
module tlpc_port_props
    import tlpc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [LAMP_W-1:0] lamps
);

    // A stalled output beat stays presented and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lamps))
        else $error("output beat changed while stalled");

    // The input side is held off only while a result waits at the output.
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty output");

    // With an empty output, a new beat always lands in the main register.
    a_no_stall_after_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> !in_stall)
        else $error("input stalled right after an empty output");

    // Every accepted input beat leaves a lamp word waiting at the output.
    a_in_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted input beat left no output beat");

    // Every delivered lamp word is one of the seven legal phase words.
    a_lamp_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lamps == LAMP_RR || lamps == LAMP_GR || lamps == LAMP_YR ||
                       lamps == LAMP_RG || lamps == LAMP_RY ||
                       lamps == LAMP_GR_PED || lamps == LAMP_RG_PED))
        else $error("illegal lamp word delivered");

endmodule

bind traffic_light_ped_controller tlpc_port_props u_tlpc_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .lamps     (lamps)
);

// ===== verif/tlpc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlpc_checker: lamp word predictor and scoreboard for the traffic light
// Watches the duration writes, the input beats and the output beats of the
// controller. Every accepted input beat advances a private copy of the light
// and queues the lamp word that must follow. Output beats are checked in order.
// ----------------------------------------------------------------------------
module tlpc_checker
    import tlpc_pkg::*;
#(
    parameter int TICK_MS = TICK_MS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]       cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   tick,
    input  logic [KEY_W-1:0]       key_edges,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [LAMP_W-1:0]      lamps,
    output int                     mismatches,
    output int                     pending,
    output int                     beats_in,
    output int                     beats_out
);

    localparam int SHOWN_MAX = 100;

    logic [DUR_W-1:0]  dur_ms [6];
    phase_t            light;
    logic              ped_shown;
    logic              ns_req;
    logic              ew_req;
    logic [DUR_W-1:0]  elapsed_ms;
    logic [LAMP_W-1:0] lamp_words_due [$];

    int fail_cnt = 0;
    int in_cnt   = 0;
    int out_cnt  = 0;

    function automatic logic [DUR_W-1:0] phase_duration();
        case (light)
            PH_RED_NS:    return dur_ms[REG_RED_BEFORE_NS];
            PH_NS_GREEN:  return dur_ms[REG_NS_GREEN];
            PH_NS_YELLOW: return dur_ms[REG_NS_YELLOW];
            PH_RED_EW:    return dur_ms[REG_RED_BEFORE_EW];
            PH_EW_GREEN:  return dur_ms[REG_EW_GREEN];
            default:      return dur_ms[REG_EW_YELLOW];
        endcase
    endfunction

    function automatic logic [LAMP_W-1:0] lamp_word();
        case (light)
            PH_NS_GREEN:  return ped_shown ? LAMP_GR_PED : LAMP_GR;
            PH_NS_YELLOW: return LAMP_YR;
            PH_EW_GREEN:  return ped_shown ? LAMP_RG_PED : LAMP_RG;
            PH_EW_YELLOW: return LAMP_RY;
            default:      return LAMP_RR;
        endcase
    endfunction

    // Applies one input beat: latch keys, add the tick, then at most one
    // phase change. The lamp word of the resulting phase is queued.
    task automatic advance_light(input logic t, input logic [KEY_W-1:0] k);
        int sum;
        if (k[0])
            ns_req = 1'b1;
        else if (k[1])
            ew_req = 1'b1;
        if (t) begin
            sum = int'(elapsed_ms) + TICK_MS;
            elapsed_ms = (sum > int'(ELAPSED_MAX)) ? ELAPSED_MAX : DUR_W'(sum);
        end
        if (elapsed_ms >= phase_duration()) begin
            elapsed_ms = '0;
            ped_shown  = 1'b0;
            case (light)
                PH_RED_NS: begin
                    light = PH_NS_GREEN;
                    if (ns_req) begin
                        ped_shown = 1'b1;
                        ns_req    = 1'b0;
                    end
                end
                PH_NS_GREEN:  light = PH_NS_YELLOW;
                PH_NS_YELLOW: light = PH_RED_EW;
                PH_RED_EW: begin
                    light = PH_EW_GREEN;
                    if (ew_req) begin
                        ped_shown = 1'b1;
                        ew_req    = 1'b0;
                    end
                end
                PH_EW_GREEN:  light = PH_EW_YELLOW;
                default:      light = PH_RED_NS;
            endcase
        end
        lamp_words_due.push_back(lamp_word());
    endtask

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= SHOWN_MAX)
            $display("%0t: %s", $time, msg);
        else if (fail_cnt == SHOWN_MAX + 1)
            $display("%0t: further lamp word failures are counted but not shown", $time);
    endtask

    always @(posedge clk or negedge rst_n) begin
        logic [LAMP_W-1:0] want;
        if (!rst_n) begin
            dur_ms[REG_RED_BEFORE_NS] = RST_RED_BEFORE_NS;
            dur_ms[REG_NS_GREEN]      = RST_NS_GREEN;
            dur_ms[REG_NS_YELLOW]     = RST_NS_YELLOW;
            dur_ms[REG_RED_BEFORE_EW] = RST_RED_BEFORE_EW;
            dur_ms[REG_EW_GREEN]      = RST_EW_GREEN;
            dur_ms[REG_EW_YELLOW]     = RST_EW_YELLOW;
            light      = PH_RED_NS;
            ped_shown  = 1'b0;
            ns_req     = 1'b0;
            ew_req     = 1'b0;
            elapsed_ms = '0;
            lamp_words_due.delete();
        end else begin
            // Spare indexes above the last duration register are ignored.
            if (cfg_we && cfg_index <= REG_EW_YELLOW)
                dur_ms[cfg_index] = cfg_data;
            if (in_valid && !in_stall) begin
                advance_light(tick, key_edges);
                in_cnt++;
            end
            if (out_valid && !out_stall) begin
                out_cnt++;
                if (lamp_words_due.size() == 0) begin
                    note_failure($sformatf(
                        "lamp beat with nothing expected: expected none, actual 8'h%02h", lamps));
                end else begin
                    want = lamp_words_due.pop_front();
                    if (lamps !== want)
                        note_failure($sformatf(
                            "lamps mismatch: expected 8'h%02h, actual 8'h%02h", want, lamps));
                end
            end
        end
        mismatches <= fail_cnt;
        pending    <= lamp_words_due.size();
        beats_in   <= in_cnt;
        beats_out  <= out_cnt;
    end

endmodule

// ===== verif/tb_traffic_light_ped_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_traffic_light_ped_controller: stimulus and verdict for the light controller
// Drives timer ticks and pedestrian key edges through the valid/stall input
// channel, stalls the lamp channel on a pattern of its own, and walks the
// controller through several duration settings. The checker beside the block
// predicts and compares every lamp word and reports its failure count here.
// ----------------------------------------------------------------------------
module tb_traffic_light_ped_controller
    import tlpc_pkg::*;
;

    localparam int TICK_MS        = TICK_MS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 3000;

    // Indexes past the last duration register. The block must ignore them.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // Opening sequence at the reset durations, one {tick, keys} beat per entry.
    // Both keys with no tick, then a tick that ends the 500 ms all-red and
    // enters the pedestrian north-south green. A north-south key while that
    // green shows stays latched, and an east-west key is latched for later.
    // Twelve ticks end the green, four the yellow, one the all-red, which
    // brings the pedestrian east-west green. Last come an empty beat, a beat
    // with a tick and both keys, and another empty beat.
    localparam logic [0:23][2:0] OPENING = {
        3'b011, 3'b100, 3'b001, 3'b010,
        {12{3'b100}},
        {4{3'b100}},
        3'b100, 3'b000, 3'b111, 3'b000
    };

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]       cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic                   tick      = 1'b0;
    logic [KEY_W-1:0]       key_edges = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [LAMP_W-1:0]      lamps;

    int mismatches;
    int pending;
    int beats_in;
    int beats_out;

    int burst_left   = 1;
    int settings_cnt = 0;
    int quiet_cycles = 0;

    traffic_light_ped_controller #(
        .TICK_MS (TICK_MS)
    ) uut (.*);

    tlpc_checker #(
        .TICK_MS (TICK_MS)
    ) checker_i (.*);

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sends one beat and waits for the edge that accepts it. The sender works
    // in bursts; at the end of a burst it may drop valid for a random gap, and
    // some bursts run straight into the next one with no gap at all.
    task automatic send_item(input logic t, input logic [KEY_W-1:0] k);
        int gap;
        in_valid  <= 1'b1;
        tick      <= t;
        key_edges <= k;
        do @(posedge clk); while (in_stall);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Random beats. Ticks are dense so that the light really moves through its
    // phases; key edges are sparse so that requests get latched and consumed
    // in many different phases. Valid is low on return.
    task automatic run_random(input int count, input int tick_pct);
        logic             t;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < count; i++) begin
            t = ($urandom_range(0, 99) < tick_pct);
            k = ($urandom_range(0, 7) == 0) ? KEY_W'($urandom_range(1, 3)) : '0;
            send_item(t, k);
        end
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DUR_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // Every beat yields a lamp word, so the block is idle as soon as the
    // checker expects nothing more. One spare index is written as well, and
    // that write must not disturb anything.
    task automatic load_durations(input logic [DUR_W-1:0] red_ns, input logic [DUR_W-1:0] g_ns,
                                  input logic [DUR_W-1:0] y_ns, input logic [DUR_W-1:0] red_ew,
                                  input logic [DUR_W-1:0] g_ew, input logic [DUR_W-1:0] y_ew);
        while (pending != 0) @(posedge clk);
        write_reg(REG_RED_BEFORE_NS, red_ns);
        write_reg(REG_NS_GREEN, g_ns);
        write_reg(REG_NS_YELLOW, y_ns);
        write_reg(REG_RED_BEFORE_EW, red_ew);
        write_reg(REG_EW_GREEN, g_ew);
        write_reg(REG_EW_YELLOW, y_ew);
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, DUR_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    // Mostly short durations so that the light cycles often, with zero and
    // the whole counter range now and then.
    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DUR_W'($urandom_range(0, ELAPSED_MAX));
            default: return DUR_W'($urandom_range(0, 3000));
        endcase
    endfunction

    // The receiver stalls in spans: free running, random stalls, a solid
    // stall that fills the skid register and pushes back on the input, or a
    // stall that toggles back and forth.
    initial begin
        int span;
        int mode;
        forever begin
            mode = $urandom_range(0, 3);
            span = (mode == 2) ? $urandom_range(1, 30) : $urandom_range(8, 60);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 35);
                    2:       out_stall <= 1'b1;
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("tb_traffic_light_ped_controller: errors");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset durations: directed opening, then random beats.
        for (int i = 0; i < 24; i++)
            send_item(OPENING[i][2], OPENING[i][1:0]);
        run_random(150, 80);

        // Zero durations: every beat leaves the current phase, tick or not.
        load_durations('0, '0, '0, '0, '0, '0);
        run_random(150, 50);

        // Longest durations: the elapsed counter has to saturate to get out.
        load_durations(ELAPSED_MAX, ELAPSED_MAX, ELAPSED_MAX,
                       ELAPSED_MAX, ELAPSED_MAX, ELAPSED_MAX);
        run_random(300, 90);

        // Durations of 9999 ms in every phase.
        load_durations(14'd9999, 14'd9999, 14'd9999, 14'd9999, 14'd9999, 14'd9999);
        run_random(200, 85);

        for (int s = 0; s < 4; s++) begin
            load_durations(pick_duration(), pick_duration(), pick_duration(),
                           pick_duration(), pick_duration(), pick_duration());
            run_random(200, 75);
        end

        // Drain, then give a late extra beat time to show up.
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d input beats and %0d lamp beats over %0d written duration sets.",
                 beats_in, beats_out, settings_cnt);
        $display("Cases: both keys at once, zero and saturating durations, spare register writes.");
        if (mismatches == 0)
            $display("tb_traffic_light_ped_controller: clean");
        else
            $display("tb_traffic_light_ped_controller: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tlpc_pkg.sv
hdl/tlpc_core.sv
hdl/traffic_light_ped_controller.sv
hdl/tlpc_checker.sv
verif/tlpc_checker.sv
verif/tb_traffic_light_ped_controller.sv
